[design/cai_pkg.sv]
// ----------------------------------------------------------------------------
// cai_pkg: shared constants for the constant-acceleration path interpolator
// Default word format and the number of interpolated axes.
// ----------------------------------------------------------------------------
package cai_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int NUM_AXES      = 3;

  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

[design/constant_accel_path_interpolator_core.sv]
// ----------------------------------------------------------------------------
// constant_accel_path_interpolator_core: constant-acceleration interpolator
// Evaluates position, velocity, heading and angular rate at a query time.
// ----------------------------------------------------------------------------
// Usage: each input transaction on the in_ stream carries a start path point,
// the end point's time and velocities and a query time. Each input transaction
// yields exactly one output transaction on the out_ stream, in order, with the
// query time echoed and the interpolated state, all signed fixed point.
// The pipeline is one input stage, one restoring-divider stage per quotient
// bit for the three accelerations, and four multiply/accumulate stages ending
// in the output register. One transaction is accepted every cycle while the
// output flows. The whole pipeline advances on a single enable: when the
// output holds an item and out_tready is low, every stage holds and in_tready
// drops, so nothing is lost or repeated. Reset clears all stage valid bits;
// the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module constant_accel_path_interpolator_core #(
  parameter int WORD_BITS     = cai_pkg::WORD_BITS,
  parameter int FRACTION_BITS = cai_pkg::FRACTION_BITS,
  parameter int IN_BITS       = (12 * WORD_BITS + 7) / 8 * 8,
  parameter int OUT_BITS      = (7 * WORD_BITS + 7) / 8 * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // fields from bit 0: start_stamp, start_x, start_y, start_heading, start_vx,
  // start_vy, start_omega, end_stamp, end_vx, end_vy, end_omega, query_stamp
  input  logic [IN_BITS-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // fields from bit 0: out_stamp, out_x, out_y, out_heading, out_vx, out_vy,
  // out_omega
  output logic [OUT_BITS-1:0] out_tdata
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int N  = W + F;
  localparam int SW = 8 * W + 4;
  localparam int NA = cai_pkg::NUM_AXES;

  cai_pkg::stage_ctl_t ctl_in;
  logic en;

  logic                 v_st [N+1];
  logic [W-1:0]         d_st [N+1];
  logic [W-1:0]         rem_st [N+1][NA];
  logic [N-1:0]         qd_st [N+1][NA];
  logic [SW-1:0]        side_st [N+1];

  logic                 out_valid;
  logic signed [W-1:0]  stamp_res;
  logic signed [W-1:0]  pos_res [NA];
  logic signed [W-1:0]  vel_res [NA];

  assign en = !out_valid || out_tready;
  assign in_tready = en;
  assign ctl_in = '{en: en, valid: in_tvalid};

  cai_front #(.W(W), .F(F), .N(N), .SW(SW)) u_front (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_in),
    .start_stamp(in_tdata[0*W +: W]),
    .start_x(in_tdata[1*W +: W]),
    .start_y(in_tdata[2*W +: W]),
    .start_heading(in_tdata[3*W +: W]),
    .start_vx(in_tdata[4*W +: W]),
    .start_vy(in_tdata[5*W +: W]),
    .start_omega(in_tdata[6*W +: W]),
    .end_stamp(in_tdata[7*W +: W]),
    .end_vx(in_tdata[8*W +: W]),
    .end_vy(in_tdata[9*W +: W]),
    .end_omega(in_tdata[10*W +: W]),
    .query_stamp(in_tdata[11*W +: W]),
    .valid_o(v_st[0]), .dmag_o(d_st[0]), .qd_o(qd_st[0]), .side_o(side_st[0])
  );

  for (genvar i = 0; i < NA; i++) begin : g_rem0
    assign rem_st[0][i] = '0;
  end

  for (genvar s = 0; s < N; s++) begin : g_div
    cai_pkg::stage_ctl_t ctl_s;
    assign ctl_s = '{en: en, valid: v_st[s]};
    cai_div_step #(.W(W), .N(N), .SW(SW)) u_step (
      .clk(clk), .rst_n(rst_n), .ctl(ctl_s),
      .d_i(d_st[s]), .rem_i(rem_st[s]), .qd_i(qd_st[s]), .side_i(side_st[s]),
      .valid_o(v_st[s+1]), .d_o(d_st[s+1]), .rem_o(rem_st[s+1]),
      .qd_o(qd_st[s+1]), .side_o(side_st[s+1])
    );
  end

  cai_pkg::stage_ctl_t ctl_back;
  assign ctl_back = '{en: en, valid: v_st[N]};

  cai_back #(.W(W), .F(F), .N(N), .SW(SW)) u_back (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_back),
    .qd_i(qd_st[N]), .side_i(side_st[N]),
    .valid_o(out_valid), .stamp_o(stamp_res), .pos_o(pos_res), .vel_o(vel_res)
  );

  assign out_tvalid = out_valid;
  assign out_tdata = OUT_BITS'({vel_res[2], vel_res[1], vel_res[0],
                                pos_res[2], pos_res[1], pos_res[0], stamp_res});

endmodule

[design/cai_front.sv]
// ----------------------------------------------------------------------------
// cai_front: input stage of the interpolator
// Registers the input item and forms the saturated time offsets and the
// velocity differences, split into magnitudes and signs for the divider.
// ----------------------------------------------------------------------------
module cai_front #(
  parameter int W = cai_pkg::WORD_BITS,
  parameter int F = cai_pkg::FRACTION_BITS,
  parameter int N = W + F,
  parameter int SW = 8 * W + 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cai_pkg::stage_ctl_t ctl,
  input  logic signed [W-1:0] start_stamp,
  input  logic signed [W-1:0] start_x,
  input  logic signed [W-1:0] start_y,
  input  logic signed [W-1:0] start_heading,
  input  logic signed [W-1:0] start_vx,
  input  logic signed [W-1:0] start_vy,
  input  logic signed [W-1:0] start_omega,
  input  logic signed [W-1:0] end_stamp,
  input  logic signed [W-1:0] end_vx,
  input  logic signed [W-1:0] end_vy,
  input  logic signed [W-1:0] end_omega,
  input  logic signed [W-1:0] query_stamp,
  output logic                valid_o,
  output logic [W-1:0]        dmag_o,
  output logic [N-1:0]        qd_o [cai_pkg::NUM_AXES],
  output logic [SW-1:0]       side_o
);

  localparam int WIDE = 2 * W + 2;
  localparam logic signed [WIDE-1:0] WMAX_L = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [WIDE-1:0] WMIN_L = ~WMAX_L;

  function automatic logic signed [W-1:0] sat(input logic signed [WIDE-1:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX_L) r = {1'b0, {(W - 1){1'b1}}};
    else if (v < WMIN_L) r = {1'b1, {(W - 1){1'b0}}};
    else r = v[W-1:0];
    return r;
  endfunction

  logic signed [W-1:0] t_c, span_c;
  logic signed [W-1:0] v0_c [cai_pkg::NUM_AXES];
  logic signed [W-1:0] v1_c [cai_pkg::NUM_AXES];
  logic signed [W-1:0] p0_c [cai_pkg::NUM_AXES];
  logic signed [W-1:0] dv_c [cai_pkg::NUM_AXES];
  logic [cai_pkg::NUM_AXES-1:0] neg_c;
  logic [SW-1:0] side_nxt;
  logic [N-1:0]  qd_nxt [cai_pkg::NUM_AXES];
  logic [W-1:0]  dmag_nxt;
  logic          valid_r;
  logic [W-1:0]  dmag_r;
  logic [N-1:0]  qd_r [cai_pkg::NUM_AXES];
  logic [SW-1:0] side_r;

  always_comb begin
    p0_c[0] = start_x;
    p0_c[1] = start_y;
    p0_c[2] = start_heading;
    v0_c[0] = start_vx;
    v0_c[1] = start_vy;
    v0_c[2] = start_omega;
    v1_c[0] = end_vx;
    v1_c[1] = end_vy;
    v1_c[2] = end_omega;
    t_c = sat(WIDE'(query_stamp) - WIDE'(start_stamp));
    span_c = sat(WIDE'(end_stamp) - WIDE'(start_stamp));
    dmag_nxt = span_c[W-1] ? W'(-span_c) : W'(span_c);
    for (int i = 0; i < cai_pkg::NUM_AXES; i++) begin
      dv_c[i] = sat(WIDE'(v1_c[i]) - WIDE'(v0_c[i]));
      neg_c[i] = dv_c[i][W-1] ^ span_c[W-1];
      qd_nxt[i] = {(dv_c[i][W-1] ? W'(-dv_c[i]) : W'(dv_c[i])), {F{1'b0}}};
    end
    side_nxt = {query_stamp, t_c, (span_c == '0), neg_c,
                p0_c[2], p0_c[1], p0_c[0], v0_c[2], v0_c[1], v0_c[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.en) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dmag_r <= dmag_nxt;
      side_r <= side_nxt;
      for (int i = 0; i < cai_pkg::NUM_AXES; i++) begin
        qd_r[i] <= qd_nxt[i];
      end
    end
  end

  assign valid_o = valid_r;
  assign dmag_o  = dmag_r;
  assign qd_o    = qd_r;
  assign side_o  = side_r;

endmodule

[design/cai_div_step.sv]
// ----------------------------------------------------------------------------
// cai_div_step: one restoring division step for all axes
// Shifts one dividend bit into each remainder, subtracts the divisor when it
// fits and shifts the quotient bit in; the side payload moves along.
// ----------------------------------------------------------------------------
module cai_div_step #(
  parameter int W = cai_pkg::WORD_BITS,
  parameter int N = W + cai_pkg::FRACTION_BITS,
  parameter int SW = 8 * W + 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cai_pkg::stage_ctl_t ctl,
  input  logic [W-1:0]        d_i,
  input  logic [W-1:0]        rem_i [cai_pkg::NUM_AXES],
  input  logic [N-1:0]        qd_i [cai_pkg::NUM_AXES],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [W-1:0]        d_o,
  output logic [W-1:0]        rem_o [cai_pkg::NUM_AXES],
  output logic [N-1:0]        qd_o [cai_pkg::NUM_AXES],
  output logic [SW-1:0]       side_o
);

  logic [W:0]   r2 [cai_pkg::NUM_AXES];
  logic         ge [cai_pkg::NUM_AXES];
  logic [W-1:0] rem_nxt [cai_pkg::NUM_AXES];
  logic [N-1:0] qd_nxt [cai_pkg::NUM_AXES];
  logic         valid_r;
  logic [W-1:0] d_r;
  logic [W-1:0] rem_r [cai_pkg::NUM_AXES];
  logic [N-1:0] qd_r [cai_pkg::NUM_AXES];
  logic [SW-1:0] side_r;

  always_comb begin
    for (int i = 0; i < cai_pkg::NUM_AXES; i++) begin
      r2[i] = {rem_i[i], qd_i[i][N-1]};
      ge[i] = r2[i] >= {1'b0, d_i};
      rem_nxt[i] = ge[i] ? W'(r2[i] - {1'b0, d_i}) : W'(r2[i]);
      qd_nxt[i] = {qd_i[i][N-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.en) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      d_r <= d_i;
      side_r <= side_i;
      for (int i = 0; i < cai_pkg::NUM_AXES; i++) begin
        rem_r[i] <= rem_nxt[i];
        qd_r[i] <= qd_nxt[i];
      end
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;
  assign rem_o   = rem_r;
  assign qd_o    = qd_r;
  assign side_o  = side_r;

endmodule

[design/cai_back.sv]
// ----------------------------------------------------------------------------
// cai_back: multiply and accumulate stages of the interpolator
// Turns the quotients into saturated accelerations and evaluates velocity
// and position over four register stages, the last being the output register.
// ----------------------------------------------------------------------------
module cai_back #(
  parameter int W = cai_pkg::WORD_BITS,
  parameter int F = cai_pkg::FRACTION_BITS,
  parameter int N = W + F,
  parameter int SW = 8 * W + 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cai_pkg::stage_ctl_t ctl,
  input  logic [N-1:0]        qd_i [cai_pkg::NUM_AXES],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic signed [W-1:0] stamp_o,
  output logic signed [W-1:0] pos_o [cai_pkg::NUM_AXES],
  output logic signed [W-1:0] vel_o [cai_pkg::NUM_AXES]
);

  localparam int NA = cai_pkg::NUM_AXES;
  localparam int WIDE = 2 * W + 2;
  localparam logic signed [WIDE-1:0] WMAX_L = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [WIDE-1:0] WMIN_L = ~WMAX_L;

  function automatic logic signed [W-1:0] sat(input logic signed [WIDE-1:0] v);
    logic signed [W-1:0] r;
    if (v > WMAX_L) r = {1'b0, {(W - 1){1'b1}}};
    else if (v < WMIN_L) r = {1'b1, {(W - 1){1'b0}}};
    else r = v[W-1:0];
    return r;
  endfunction

  logic signed [W-1:0] q_in, t_in;
  logic                zero_in;
  logic [NA-1:0]       neg_in;
  logic signed [W-1:0] p0_in [NA];
  logic signed [W-1:0] v0_in [NA];
  logic signed [W-1:0] a_nxt [NA];

  always_comb begin
    q_in    = side_i[8*W+3 -: W];
    t_in    = side_i[7*W+3 -: W];
    zero_in = side_i[6*W+3];
    neg_in  = side_i[6*W+2 -: NA];
    for (int i = 0; i < NA; i++) begin
      p0_in[i] = side_i[(3 + i) * W +: W];
      v0_in[i] = side_i[i * W +: W];
      if (zero_in) begin
        a_nxt[i] = '0;
      end else if (!neg_in[i]) begin
        a_nxt[i] = (|qd_i[i][N-1:W-1]) ? {1'b0, {(W - 1){1'b1}}} : qd_i[i][W-1:0];
      end else if ((|qd_i[i][N-1:W]) || (qd_i[i][W-1] && (|qd_i[i][W-2:0]))) begin
        a_nxt[i] = {1'b1, {(W - 1){1'b0}}};
      end else begin
        a_nxt[i] = W'(-qd_i[i][W-1:0]);
      end
    end
  end

  logic [3:0] valid_r;
  logic signed [W-1:0]   qa_r, ta_r;
  logic signed [2*W-1:0] tt_r;
  logic signed [W-1:0]   aa_r [NA];
  logic signed [W-1:0]   pa_r [NA];
  logic signed [W-1:0]   va_r [NA];

  logic signed [W-1:0]   qb_r, t2b_r;
  logic signed [W-1:0]   ab_r [NA];
  logic signed [W-1:0]   pb_r [NA];
  logic signed [W-1:0]   vb_r [NA];
  logic signed [2*W-1:0] atb_r [NA];
  logic signed [2*W-1:0] vtb_r [NA];

  logic signed [W-1:0]   qc_r;
  logic signed [W-1:0]   pc_r [NA];
  logic signed [W-1:0]   velc_r [NA];
  logic signed [2*W-1:0] at2c_r [NA];
  logic signed [2*W-1:0] fvc_r [NA];

  logic signed [W-1:0]   qd_r;
  logic signed [W-1:0]   posd_r [NA];
  logic signed [W-1:0]   veld_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.en) begin
      valid_r <= {valid_r[2:0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      qa_r <= q_in;
      ta_r <= t_in;
      tt_r <= t_in * t_in;
      qb_r <= qa_r;
      t2b_r <= sat(WIDE'(tt_r >>> F));
      qc_r <= qb_r;
      qd_r <= qc_r;
      for (int i = 0; i < NA; i++) begin
        aa_r[i] <= a_nxt[i];
        pa_r[i] <= p0_in[i];
        va_r[i] <= v0_in[i];
        ab_r[i] <= aa_r[i];
        pb_r[i] <= pa_r[i];
        vb_r[i] <= va_r[i];
        atb_r[i] <= aa_r[i] * ta_r;
        vtb_r[i] <= va_r[i] * ta_r;
        pc_r[i] <= pb_r[i];
        at2c_r[i] <= ab_r[i] * t2b_r;
        fvc_r[i] <= vtb_r[i] >>> F;
        velc_r[i] <= sat(WIDE'(atb_r[i] >>> F) + WIDE'(vb_r[i]));
        posd_r[i] <= sat(WIDE'(at2c_r[i] >>> (F + 1)) + WIDE'(fvc_r[i]) + WIDE'(pc_r[i]));
        veld_r[i] <= velc_r[i];
      end
    end
  end

  assign valid_o = valid_r[3];
  assign stamp_o = qd_r;
  assign pos_o   = posd_r;
  assign vel_o   = veld_r;

endmodule

[dv/cai_checker.sv]
// ----------------------------------------------------------------------------
// cai_checker: scoreboard for the constant-acceleration path interpolator
// Watches both streams, predicts each output transaction from the accepted
// input transaction and compares it field by field in order.
// ----------------------------------------------------------------------------
module cai_checker #(
  parameter int IN_BITS  = 384,
  parameter int OUT_BITS = 224
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IN_BITS-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_BITS-1:0] out_tdata,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = cai_pkg::WORD_BITS;
  localparam int F = cai_pkg::FRACTION_BITS;
  localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;

  logic [OUT_BITS-1:0] expected_states[$];
  string field_names[7] = '{"out_stamp", "out_x", "out_y", "out_heading",
                            "out_vx", "out_vy", "out_omega"};

  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint fixed_mul(longint a, longint b);
    return (a * b) >>> F;
  endfunction

  function automatic longint field_of(logic [IN_BITS-1:0] d, int i);
    logic signed [W-1:0] f;
    f = d[i*W +: W];
    return longint'(f);
  endfunction

  function automatic void interp_axis(longint p0, longint v0, longint v1, longint span,
                                      longint t, longint t2,
                                      output longint pos, output longint vel);
    longint acc;
    acc = 0;
    if (span != 0) acc = clamp_word((clamp_word(v1 - v0) * (64'sd1 <<< F)) / span);
    pos = clamp_word(((acc * t2) >>> (F + 1)) + fixed_mul(v0, t) + p0);
    vel = clamp_word(fixed_mul(acc, t) + v0);
  endfunction

  function automatic logic [OUT_BITS-1:0] predict_state(logic [IN_BITS-1:0] d);
    longint s0, s1, q, t, span, t2;
    longint r[7];
    logic [OUT_BITS-1:0] o;
    s0 = field_of(d, 0);
    s1 = field_of(d, 7);
    q = field_of(d, 11);
    t = clamp_word(q - s0);
    span = clamp_word(s1 - s0);
    t2 = clamp_word(fixed_mul(t, t));
    r[0] = q;
    interp_axis(field_of(d, 1), field_of(d, 4), field_of(d, 8), span, t, t2, r[1], r[4]);
    interp_axis(field_of(d, 2), field_of(d, 5), field_of(d, 9), span, t, t2, r[2], r[5]);
    interp_axis(field_of(d, 3), field_of(d, 6), field_of(d, 10), span, t, t2, r[3], r[6]);
    o = '0;
    for (int i = 0; i < 7; i++) o[i*W +: W] = r[i][W-1:0];
    return o;
  endfunction

  assign pending_count = expected_states.size();

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] exp_d;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_states.push_back(predict_state(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_states.size() == 0) begin
          $error("unexpected output transaction %h", out_tdata);
          errs = errs + 1;
        end else begin
          exp_d = expected_states.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (out_tdata[i*W +: W] !== exp_d[i*W +: W]) begin
              $error("%s expected %h actual %h", field_names[i], exp_d[i*W +: W],
                     out_tdata[i*W +: W]);
              errs = errs + 1;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[dv/tb_constant_accel_path_interpolator_core.sv]
// ----------------------------------------------------------------------------
// tb_constant_accel_path_interpolator_core: stream test of the interpolator
// Sends directed and random path segments with bursty input and stalling
// output; the checker predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_constant_accel_path_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W        = cai_pkg::WORD_BITS;
  localparam int IN_BITS  = (12 * W + 7) / 8 * 8;
  localparam int OUT_BITS = (7 * W + 7) / 8 * 8;
  localparam int NUM_RANDOM = 450;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  int fail_count, pending_count, idle_cycles;
  logic [IN_BITS-1:0] segments[$];

  always #2 clk = ~clk;

  constant_accel_path_interpolator_core u_dut (.*);

  cai_checker #(.IN_BITS(IN_BITS), .OUT_BITS(OUT_BITS)) u_checker (.*);

  function automatic logic [W-1:0] pick_word(int mode);
    case (mode)
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2: return '0;
      3: return W'($urandom_range(0, 'h3ffff)) - W'('h20000);
      default: return W'($urandom());
    endcase
  endfunction

  // Segment: unless wild, small times with end not before start, moderate values.
  function automatic logic [IN_BITS-1:0] make_segment(bit wild);
    logic [IN_BITS-1:0] d;
    logic [W-1:0] s0;
    for (int i = 0; i < 12; i++)
      d[i*W +: W] = wild ? pick_word($urandom_range(0, 5)) : pick_word(3);
    if (!wild) begin
      s0 = W'($urandom_range(0, 'hfffff));
      d[0 +: W] = s0;
      d[7*W +: W] = s0 + W'($urandom_range(0, 'h4ffff));
      d[11*W +: W] = s0 + W'($urandom_range(0, 'h6ffff)) - W'('h10000);
    end
    return d;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7) || (($urandom() & 64) != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [IN_BITS-1:0] d;
    int burst;
    for (int m = 0; m < 5; m++) begin
      d = '0;
      for (int i = 0; i < 12; i++) d[i*W +: W] = pick_word(m);
      segments.push_back(d);
    end
    d = make_segment(1'b0);
    d[7*W +: W] = d[0 +: W];
    segments.push_back(d);
    for (int i = 0; i < 12; i++) begin
      d = make_segment(1'b0);
      d[i*W +: W] = pick_word(i % 2);
      segments.push_back(d);
    end
    for (int k = 0; k < 6; k++) segments.push_back(make_segment(1'b1));
    for (int k = 0; k < NUM_RANDOM; k++) segments.push_back(make_segment($urandom_range(0, 4) == 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (segments.size() > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && segments.size() > 0) begin
        @(posedge clk);
        in_tvalid <= 1'b1;
        in_tdata <= segments.pop_front();
        do @(posedge clk); while (!in_tready);
        burst--;
        if (burst > 0 && segments.size() > 0) begin
          in_tdata <= segments.pop_front();
          while (burst > 1 && segments.size() > 0) begin
            do @(posedge clk); while (!in_tready);
            in_tdata <= segments.pop_front();
            burst--;
          end
          do @(posedge clk); while (!in_tready);
          burst = 0;
        end
        in_tvalid <= 1'b0;
      end
      repeat ($urandom_range(0, 8)) @(posedge clk);
    end
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[constant_accel_path_interpolator_core.f]
design/cai_pkg.sv
design/cai_front.sv
design/cai_div_step.sv
design/cai_back.sv
design/constant_accel_path_interpolator_core.sv
dv/cai_checker.sv
dv/tb_constant_accel_path_interpolator_core.sv
